@@ sv/dict_pkg.sv @@
package dict_pkg;

   localparam int ELEM_WIDTH  = 32;
   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH = ADDR_WIDTH + 1;
   localparam int INDEX_WIDTH = 9;

   typedef logic [ELEM_WIDTH-1:0]  elem_type;
   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

   // write port of the entry store
   typedef struct packed {
      logic     en;
      addr_type addr;
      elem_type data;
   } store_wr_type;

   // read port of the entry store
   typedef struct packed {
      logic     en;
      addr_type addr;
   } store_rd_type;

endpackage

@@ sv/dict_ifs.sv @@
interface dict_req_if;
   import dict_pkg::*;

   logic     valid;
   logic     ready;
   elem_type value;
   logic     start_set;

   modport source (output valid, value, start_set, input ready);
   modport sink   (input valid, value, start_set, output ready);
endinterface

interface dict_rsp_if;
   import dict_pkg::*;

   logic      valid;
   logic      ready;
   index_type index;
   logic      is_new;
   logic      overflow;

   modport source (output valid, index, is_new, overflow, input ready);
   modport sink   (input valid, index, is_new, overflow, output ready);
endinterface

@@ sv/dictionary_encoder.sv @@
// Result: an item whose value sits at entry k gives its result after a scan of entries
// 0 to k; a new value gives its result after a scan of all n stored entries.
// Throughput: one item per scan, one compare per cycle on the single read port of the
// entry store; no new item is taken until the last result is in the output register.
// Reset: clears the entry count and the handshakes; the entry store is not cleared,
// as only entries below the count are ever read.
module dictionary_encoder (
   input logic        clock,
   input logic        reset,
   dict_req_if.sink   req_chan,
   dict_rsp_if.source rsp_chan
);
   import dict_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]   state_ff, state_in;
   count_type    count_ff, count_in;
   count_type    issue_pos_ff, issue_pos_in;
   logic         pend_ff, pend_in;
   count_type    pend_pos_ff, pend_pos_in;
   elem_type     val_ff, val_in;
   index_type    res_index_ff, res_index_in;
   logic         res_new_ff, res_new_in;
   logic         res_ovf_ff, res_ovf_in;
   logic         rsp_valid_ff, rsp_valid_in;
   index_type    rsp_index_ff, rsp_index_in;
   logic         rsp_new_ff, rsp_new_in;
   logic         rsp_ovf_ff, rsp_ovf_in;
   store_wr_type wr;
   store_rd_type rd;
   elem_type     rd_data;
   logic         req_take;
   logic         rsp_take;
   logic         hit;
   logic         miss;

   dict_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   assign hit  = (state_ff == ST_SCAN) && pend_ff && (rd_data == val_ff);
   assign miss = (state_ff == ST_SCAN) && !pend_ff && (issue_pos_ff == count_ff);

   // sequencer: issue one read a cycle, compare the entry that comes back
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_pos_in = issue_pos_ff;
      pend_in      = 1'b0;
      pend_pos_in  = pend_pos_ff;
      val_in       = val_ff;
      res_index_in = res_index_ff;
      res_new_in   = res_new_ff;
      res_ovf_in   = res_ovf_ff;
      rd.en        = 1'b0;
      rd.addr      = issue_pos_ff[ADDR_WIDTH-1:0];
      wr.en        = 1'b0;
      wr.addr      = count_ff[ADDR_WIDTH-1:0];
      wr.data      = val_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               val_in       = req_chan.value;
               issue_pos_in = '0;
               if (req_chan.start_set) begin
                  count_in = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_index_in = index_type'(pend_pos_ff);
               res_new_in   = 1'b0;
               res_ovf_in   = 1'b0;
               state_in     = ST_HOLD;
            end else if (miss) begin
               res_index_in = index_type'(count_ff);
               if (count_ff < count_type'(TABLE_DEPTH)) begin
                  // append the value
                  wr.en      = 1'b1;
                  count_in   = count_ff + count_type'(1);
                  res_new_in = 1'b1;
                  res_ovf_in = 1'b0;
               end else begin
                  res_new_in = 1'b0;
                  res_ovf_in = 1'b1;
               end
               state_in = ST_HOLD;
            end else if (issue_pos_ff < count_ff) begin
               rd.en        = 1'b1;
               pend_in      = 1'b1;
               pend_pos_in  = issue_pos_ff;
               issue_pos_in = issue_pos_ff + count_type'(1);
            end
         end
         ST_HOLD: begin
            // wait for the output register to free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (state_ff == ST_HOLD && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = res_index_ff;
         rsp_new_in   = res_new_ff;
         rsp_ovf_in   = res_ovf_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      issue_pos_ff <= issue_pos_in;
      pend_pos_ff  <= pend_pos_in;
      val_ff       <= val_in;
      res_index_ff <= res_index_in;
      res_new_ff   <= res_new_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.index    = rsp_index_ff;
   assign rsp_chan.is_new   = rsp_new_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

endmodule

@@ sv/dict_store.sv @@
module dict_store (
   input  logic                   clock,
   input  dict_pkg::store_wr_type wr,
   input  dict_pkg::store_rd_type rd,
   output dict_pkg::elem_type     rd_data
);
   import dict_pkg::*;

   elem_type mem [TABLE_DEPTH];
   elem_type rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read one entry, data registered
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
